FILE: rtl/imfl_pkg.sv
// ----------------------------------------------------------------------------
// imfl_pkg: shared types and constants of the image flip address stream
// Field widths, register indexes and the controller/datapath command and
// status structs.
// ----------------------------------------------------------------------------
package imfl_pkg;

    // Payload widths
    localparam int BYTE_W     = 8;
    localparam int ADDR_W     = 26;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    // Register field widths
    localparam int DIM_W = 13;
    localparam int BPP_W = 3;
    localparam int PAD_W = 8;
    localparam int BIP_W = 2;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH     = 3'd0,
        REG_IMAGE_HEIGHT    = 3'd1,
        REG_BYTES_PER_PIXEL = 3'd2,
        REG_ROW_PAD         = 3'd3,
        REG_MIRROR_X        = 3'd4,
        REG_MIRROR_Y        = 3'd5
    } cfg_reg_idx_t;

    // Controller to datapath commands
    typedef struct packed {
        logic setup_mul;   // form row stride and column span
        logic setup_row;   // form offset of the last row
        logic init_pos;    // load start address, clear counters
        logic step;        // input transaction accepted
    } dp_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic pad;         // current input byte is row padding
    } dp_stat_t;

endpackage

FILE: rtl/imfl_if.sv
// ----------------------------------------------------------------------------
// imfl_if: channel interfaces of the image flip address stream
// Input byte channel, output address/byte channel and register write channel.
// ----------------------------------------------------------------------------
interface imfl_in_if;
    logic                          valid;
    logic                          ready;
    logic [imfl_pkg::BYTE_W-1:0]   in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface imfl_out_if;
    logic                          valid;
    logic                          ready;
    logic [imfl_pkg::ADDR_W-1:0]   out_addr;
    logic [imfl_pkg::BYTE_W-1:0]   out_byte;
    logic                          last_byte;

    modport source (output valid, output out_addr, output out_byte, output last_byte,
                    input ready);
    modport sink   (input valid, input out_addr, input out_byte, input last_byte,
                    output ready);
endinterface

interface imfl_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [imfl_pkg::CFG_IDX_W-1:0]    index;
    logic [imfl_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/image_flip_address_stream.sv
// ----------------------------------------------------------------------------
// image_flip_address_stream: mirrored destination addresses for a byte stream
// Turns a padded raster byte stream into (address, byte) writes of an
// unpadded, optionally mirrored destination image.
// ----------------------------------------------------------------------------
// Usage: after reset and after every register write to a known index the block
// rebuilds its geometry in three steps with in_stream.ready low: row stride and
// column span first, then the last-row offset, then the start address.
// Register writes are taken in any cycle. From then on it takes one byte per
// cycle: the pixel address is walked by add/subtract of bytes_per_pixel and
// the row stride, and each pixel byte is loaded into a single output register
// at its transaction, valid from the next cycle. A byte is taken only while
// that register is empty or being taken in the same cycle, so a result that
// waits holds off the input. Padding bytes are consumed at the same rate and
// produce nothing. A write to a known index restarts the stream at row 0,
// column 0; write registers only while the block is idle.
module image_flip_address_stream #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic               clk,
    input  logic               rst_n,
    imfl_in_if.sink            in_stream,
    imfl_out_if.source         out_stream,
    imfl_cfg_if.sink           cfg
);

    localparam int WC_W = $clog2(MAX_WIDTH + 1);
    localparam int HC_W = $clog2(MAX_HEIGHT + 1);

    imfl_pkg::dp_cmd_t            cmd;
    imfl_pkg::dp_stat_t           stat;
    logic                         restart;
    logic                         cfg_we;
    logic [WC_W-1:0]              width_c;
    logic [HC_W-1:0]              height_c;
    logic [imfl_pkg::BPP_W-1:0]   bpp_c;
    logic [imfl_pkg::PAD_W-1:0]   row_pad;
    logic                         mirror_x;
    logic                         mirror_y;

    // Register writes are always taken
    assign cfg.ready = 1'b1;
    assign cfg_we    = cfg.valid && cfg.ready;

    imfl_cfg_regs #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_we),
        .wr_index (cfg.index),
        .wr_data  (cfg.data),
        .restart  (restart),
        .width_c  (width_c),
        .height_c (height_c),
        .bpp_c    (bpp_c),
        .row_pad  (row_pad),
        .mirror_x (mirror_x),
        .mirror_y (mirror_y)
    );

    imfl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .restart   (restart),
        .in_valid  (in_stream.valid),
        .in_ready  (in_stream.ready),
        .out_valid (out_stream.valid),
        .out_ready (out_stream.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    imfl_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .width_c   (width_c),
        .height_c  (height_c),
        .bpp_c     (bpp_c),
        .row_pad   (row_pad),
        .mirror_x  (mirror_x),
        .mirror_y  (mirror_y),
        .in_byte   (in_stream.in_byte),
        .out_addr  (out_stream.out_addr),
        .out_byte  (out_stream.out_byte),
        .last_byte (out_stream.last_byte)
    );

    // A restart holds off input while the geometry is rebuilt
    a_restart_blocks_input: assert property (
        @(posedge clk) disable iff (!rst_n)
        restart |=> !in_stream.ready
    ) else $error("input accepted right after a register write");

    // A pixel transaction always presents a result
    a_pixel_gives_result: assert property (
        @(posedge clk) disable iff (!rst_n)
        (cmd.step && !stat.pad) |=> out_stream.valid
    ) else $error("pixel transaction produced no result");

    // A padding transaction never creates a result
    a_pad_gives_none: assert property (
        @(posedge clk) disable iff (!rst_n)
        (cmd.step && stat.pad && !out_stream.valid) |=> !out_stream.valid
    ) else $error("padding transaction produced a result");

endmodule

FILE: rtl/imfl_cfg_regs.sv
// ----------------------------------------------------------------------------
// imfl_cfg_regs: configuration registers
// Holds the six registers, flags a restart on any known index and presents
// the clamped image geometry.
// ----------------------------------------------------------------------------
module imfl_cfg_regs #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096,
    localparam int WC_W = $clog2(MAX_WIDTH + 1),
    localparam int HC_W = $clog2(MAX_HEIGHT + 1)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          wr_en,
    input  logic [imfl_pkg::CFG_IDX_W-1:0]  wr_index,
    input  logic [imfl_pkg::CFG_DATA_W-1:0] wr_data,
    output logic                          restart,
    output logic [WC_W-1:0]               width_c,
    output logic [HC_W-1:0]               height_c,
    output logic [imfl_pkg::BPP_W-1:0]    bpp_c,
    output logic [imfl_pkg::PAD_W-1:0]    row_pad,
    output logic                          mirror_x,
    output logic                          mirror_y
);

    logic [imfl_pkg::DIM_W-1:0] width_reg,  width_next;
    logic [imfl_pkg::DIM_W-1:0] height_reg, height_next;
    logic [imfl_pkg::BPP_W-1:0] bpp_reg,    bpp_next;
    logic [imfl_pkg::PAD_W-1:0] pad_reg,    pad_next;
    logic                       mx_reg,     mx_next;
    logic                       my_reg,     my_next;
    logic                       known_idx;

    // Decode the register write
    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        bpp_next    = bpp_reg;
        pad_next    = pad_reg;
        mx_next     = mx_reg;
        my_next     = my_reg;
        known_idx   = 1'b1;
        unique case (wr_index)
            imfl_pkg::REG_IMAGE_WIDTH:     width_next  = wr_data[imfl_pkg::DIM_W-1:0];
            imfl_pkg::REG_IMAGE_HEIGHT:    height_next = wr_data[imfl_pkg::DIM_W-1:0];
            imfl_pkg::REG_BYTES_PER_PIXEL: bpp_next    = wr_data[imfl_pkg::BPP_W-1:0];
            imfl_pkg::REG_ROW_PAD:         pad_next    = wr_data[imfl_pkg::PAD_W-1:0];
            imfl_pkg::REG_MIRROR_X:        mx_next     = wr_data[0];
            imfl_pkg::REG_MIRROR_Y:        my_next     = wr_data[0];
            default:                       known_idx   = 1'b0;
        endcase
    end

    assign restart = wr_en && known_idx;

    // Hold the registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= imfl_pkg::DIM_W'(1);
            height_reg <= imfl_pkg::DIM_W'(1);
            bpp_reg    <= imfl_pkg::BPP_W'(4);
            pad_reg    <= '0;
            mx_reg     <= 1'b0;
            my_reg     <= 1'b0;
        end
        else if (wr_en)
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
            bpp_reg    <= bpp_next;
            pad_reg    <= pad_next;
            mx_reg     <= mx_next;
            my_reg     <= my_next;
        end
    end

    // Clamp geometry: zero reads as one, large values saturate
    always_comb
    begin
        if (width_reg == '0)
            width_c = WC_W'(1);
        else if (32'(width_reg) > 32'(MAX_WIDTH))
            width_c = WC_W'(MAX_WIDTH);
        else
            width_c = WC_W'(width_reg);

        if (height_reg == '0)
            height_c = HC_W'(1);
        else if (32'(height_reg) > 32'(MAX_HEIGHT))
            height_c = HC_W'(MAX_HEIGHT);
        else
            height_c = HC_W'(height_reg);

        if (bpp_reg == '0)
            bpp_c = imfl_pkg::BPP_W'(1);
        else if (bpp_reg > imfl_pkg::BPP_W'(4))
            bpp_c = imfl_pkg::BPP_W'(4);
        else
            bpp_c = bpp_reg;
    end

    assign row_pad  = pad_reg;
    assign mirror_x = mx_reg;
    assign mirror_y = my_reg;

endmodule

FILE: rtl/imfl_ctrl.sv
// ----------------------------------------------------------------------------
// imfl_ctrl: sequencing controller
// Runs the geometry setup after reset or a register write, then paces input
// transactions against the output register.
// ----------------------------------------------------------------------------
module imfl_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                restart,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  imfl_pkg::dp_stat_t  stat,
    output imfl_pkg::dp_cmd_t   cmd
);

    typedef enum logic [3:0] {
        ST_SETUP_MUL = 4'b0001,
        ST_SETUP_ROW = 4'b0010,
        ST_SETUP_POS = 4'b0100,
        ST_RUN       = 4'b1000
    } ctrl_state_t;

    ctrl_state_t state_reg, state_next;
    logic        ovalid_reg, ovalid_next;
    logic        accept;

    // Accept while running and the output register is free or draining
    assign in_ready = (state_reg == ST_RUN) && (!ovalid_reg || out_ready);
    assign accept   = in_valid && in_ready;

    // Advance the setup sequence
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_SETUP_MUL: state_next = ST_SETUP_ROW;
            ST_SETUP_ROW: state_next = ST_SETUP_POS;
            ST_SETUP_POS: state_next = ST_RUN;
            ST_RUN:       state_next = ST_RUN;
            default:      state_next = ST_SETUP_MUL;
        endcase
        if (restart)
            state_next = ST_SETUP_MUL;
    end

    // Output valid: load on a pixel transaction, drop when taken
    always_comb
    begin
        priority if (accept && !stat.pad)
            ovalid_next = 1'b1;
        else if (out_ready)
            ovalid_next = 1'b0;
        else
            ovalid_next = ovalid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_SETUP_MUL;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
        end
    end

    assign out_valid     = ovalid_reg;
    assign cmd.setup_mul = (state_reg == ST_SETUP_MUL);
    assign cmd.setup_row = (state_reg == ST_SETUP_ROW);
    assign cmd.init_pos  = (state_reg == ST_SETUP_POS);
    assign cmd.step      = accept;

endmodule

FILE: rtl/imfl_datapath.sv
// ----------------------------------------------------------------------------
// imfl_datapath: position counters and destination address
// Keeps column, row, byte and padding counters and walks the mirrored pixel
// address incrementally; registers the result for the output channel.
// ----------------------------------------------------------------------------
module imfl_datapath #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096,
    localparam int WC_W  = $clog2(MAX_WIDTH + 1),
    localparam int HC_W  = $clog2(MAX_HEIGHT + 1),
    localparam int COL_W = $clog2(MAX_WIDTH),
    localparam int ROW_W = $clog2(MAX_HEIGHT)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  imfl_pkg::dp_cmd_t             cmd,
    output imfl_pkg::dp_stat_t            stat,
    input  logic [WC_W-1:0]               width_c,
    input  logic [HC_W-1:0]               height_c,
    input  logic [imfl_pkg::BPP_W-1:0]    bpp_c,
    input  logic [imfl_pkg::PAD_W-1:0]    row_pad,
    input  logic                          mirror_x,
    input  logic                          mirror_y,
    input  logic [imfl_pkg::BYTE_W-1:0]   in_byte,
    output logic [imfl_pkg::ADDR_W-1:0]   out_addr,
    output logic [imfl_pkg::BYTE_W-1:0]   out_byte,
    output logic                          last_byte
);

    localparam int AW = imfl_pkg::ADDR_W;

    // Geometry products, formed during setup
    logic [AW-1:0] stride_reg;
    logic [AW-1:0] colspan_reg;
    logic [AW-1:0] lastrow_reg;

    // Position and address walk
    logic [COL_W-1:0]             col_reg,  col_next;
    logic [ROW_W-1:0]             row_reg,  row_next;
    logic [imfl_pkg::BIP_W-1:0]   bip_reg,  bip_next;
    logic [imfl_pkg::PAD_W-1:0]   padc_reg, padc_next;
    logic                         inpad_reg, inpad_next;
    logic [AW-1:0]                rowbase_reg, rowbase_next;
    logic [AW-1:0]                pix_reg,  pix_next;

    // Output payload
    logic [AW-1:0]                addr_reg;
    logic [imfl_pkg::BYTE_W-1:0]  byte_reg;
    logic                         last_reg;

    logic col_last, row_last, bip_last, pad_done;
    logic [AW-1:0] bpp_ext;
    logic [AW-1:0] row_start;

    assign bpp_ext  = AW'(bpp_c);
    assign col_last = (WC_W'(col_reg) == width_c - WC_W'(1));
    assign row_last = (HC_W'(row_reg) == height_c - HC_W'(1));
    assign bip_last = ({1'b0, bip_reg} == bpp_c - imfl_pkg::BPP_W'(1));
    assign pad_done = ({1'b0, padc_reg} + 9'd1) >= {1'b0, row_pad};

    // Setup products: stride and span first, last-row offset after
    always_ff @(posedge clk)
    begin
        if (cmd.setup_mul)
        begin
            stride_reg  <= AW'(width_c) * bpp_ext;
            colspan_reg <= AW'(width_c - WC_W'(1)) * bpp_ext;
        end
        if (cmd.setup_row)
            lastrow_reg <= AW'(height_c - HC_W'(1)) * stride_reg;
    end

    // Counters and address walk
    always_comb
    begin
        col_next     = col_reg;
        row_next     = row_reg;
        bip_next     = bip_reg;
        padc_next    = padc_reg;
        inpad_next   = inpad_reg;
        rowbase_next = rowbase_reg;
        pix_next     = pix_reg;
        row_start    = '0;

        if (cmd.init_pos)
        begin
            col_next     = '0;
            row_next     = '0;
            bip_next     = '0;
            padc_next    = '0;
            inpad_next   = 1'b0;
            rowbase_next = mirror_y ? lastrow_reg : '0;
            pix_next     = rowbase_next + (mirror_x ? colspan_reg : '0);
        end
        else if (cmd.step && inpad_reg)
        begin
            // Drop padding bytes
            padc_next = padc_reg + imfl_pkg::PAD_W'(1);
            if (pad_done)
            begin
                padc_next  = '0;
                inpad_next = 1'b0;
            end
        end
        else if (cmd.step)
        begin
            bip_next = bip_reg + imfl_pkg::BIP_W'(1);
            if (bip_last)
            begin
                bip_next = '0;
                if (!col_last)
                begin
                    col_next = col_reg + COL_W'(1);
                    pix_next = mirror_x ? pix_reg - bpp_ext : pix_reg + bpp_ext;
                end
                else
                begin
                    // Wrap to the next row, or back to the first at image end
                    col_next = '0;
                    if (row_last)
                    begin
                        row_next  = '0;
                        row_start = mirror_y ? lastrow_reg : '0;
                    end
                    else
                    begin
                        row_next  = row_reg + ROW_W'(1);
                        row_start = mirror_y ? rowbase_reg - stride_reg
                                             : rowbase_reg + stride_reg;
                    end
                    rowbase_next = row_start;
                    pix_next     = row_start + (mirror_x ? colspan_reg : '0);
                    if (row_pad != '0)
                    begin
                        inpad_next = 1'b1;
                        padc_next  = '0;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg   <= '0;
            row_reg   <= '0;
            bip_reg   <= '0;
            padc_reg  <= '0;
            inpad_reg <= 1'b0;
        end
        else
        begin
            col_reg   <= col_next;
            row_reg   <= row_next;
            bip_reg   <= bip_next;
            padc_reg  <= padc_next;
            inpad_reg <= inpad_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rowbase_reg <= rowbase_next;
        pix_reg     <= pix_next;
    end

    // Load the output register on a pixel transaction
    always_ff @(posedge clk)
    begin
        if (cmd.step && !inpad_reg)
        begin
            addr_reg <= pix_reg + AW'(bip_reg);
            byte_reg <= in_byte;
            last_reg <= row_last && col_last && bip_last;
        end
    end

    assign stat.pad  = inpad_reg;
    assign out_addr  = addr_reg;
    assign out_byte  = byte_reg;
    assign last_byte = last_reg;

endmodule
